### src/sttcq_pkg.sv
// Shared types and constants for the stack-to-two-class-queues block.
package sttcq_pkg;

	localparam int CODE_BITS       = 7;
	localparam int OP_BITS         = 2;
	localparam int STATUS_BITS     = 3;
	localparam int COUNT_BITS      = 4;
	localparam int LIMIT_BITS      = 4;
	localparam int STACK_DEPTH_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd8;

	typedef enum logic [OP_BITS-1:0] {
		OP_REGISTER   = 2'd0,
		OP_DISTRIBUTE = 2'd1,
		OP_SEND       = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE        = 3'd0,
		ST_STACK_FULL  = 3'd1,
		ST_STACK_EMPTY = 3'd2,
		ST_QUEUE_EMPTY = 3'd3,
		ST_QUEUE_FULL  = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

### src/sttcq_if.sv
// Request and response channel interfaces.
interface sttcq_req_if;
	logic                                valid;
	logic                                ready;
	logic [sttcq_pkg::OP_BITS-1:0]       operation;
	logic [sttcq_pkg::CODE_BITS-1:0]     item_code;
	logic                                item_international;
	logic                                queue_select;

	modport source (output valid, operation, item_code, item_international, queue_select,
		input ready);
	modport sink (input valid, operation, item_code, item_international, queue_select,
		output ready);
endinterface

interface sttcq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [sttcq_pkg::STATUS_BITS-1:0]   status;
	logic [sttcq_pkg::CODE_BITS-1:0]     out_code;
	logic                                out_international;
	logic [sttcq_pkg::COUNT_BITS-1:0]    stack_count;

	modport source (output valid, status, out_code, out_international, stack_count,
		input ready);
	modport sink (input valid, status, out_code, out_international, stack_count,
		output ready);
endinterface

### src/sttcq_ctrl.sv
// Controller: sequences capture and commit of one operation at a time.
module sttcq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sttcq_pkg::dp_status_t  stat,
	output sttcq_pkg::ctrl_cmd_t   cmd
);

	sttcq_pkg::state_t state_q;
	sttcq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sttcq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sttcq_pkg::S_IDLE: begin
				if (in_valid) state_d = sttcq_pkg::S_EXEC;
			end
			sttcq_pkg::S_EXEC: begin
				if (stat.out_free) state_d = sttcq_pkg::S_IDLE;
			end
			default: state_d = sttcq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			sttcq_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			sttcq_pkg::S_EXEC: begin
				// wait here while the result register is held by the receiver
				cmd.commit = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

### src/sttcq_dp.sv
// Datapath: stack and queue memories, pointers, limit register, result register.
module sttcq_dp #(
	parameter int STACK_DEPTH = sttcq_pkg::STACK_DEPTH_DEF,
	parameter int QUEUE_DEPTH = sttcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sttcq_pkg::LIMIT_BITS-1:0]    cfg_wdata,
	input  logic [sttcq_pkg::OP_BITS-1:0]       operation,
	input  logic [sttcq_pkg::CODE_BITS-1:0]     item_code,
	input  logic                                item_international,
	input  logic                                queue_select,
	input  sttcq_pkg::ctrl_cmd_t                cmd,
	output sttcq_pkg::dp_status_t               stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sttcq_pkg::STATUS_BITS-1:0]   status,
	output logic [sttcq_pkg::CODE_BITS-1:0]     out_code,
	output logic                                out_international,
	output logic [sttcq_pkg::COUNT_BITS-1:0]    stack_count
);

	localparam int CB    = sttcq_pkg::CODE_BITS;
	localparam int LB    = sttcq_pkg::LIMIT_BITS;
	localparam int CNT_W = sttcq_pkg::COUNT_BITS;
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int QA_W  = $clog2(QUEUE_DEPTH);
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (SP_W > LB) ? SP_W : LB;
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(STACK_DEPTH);
	localparam logic [QC_W-1:0]  Q_FULL    = QC_W'(QUEUE_DEPTH);
	localparam logic [QC_W:0]    Q_WRAP    = (QC_W + 1)'(QUEUE_DEPTH);
	localparam logic [QA_W-1:0]  Q_LAST    = QA_W'(QUEUE_DEPTH - 1);

	// storage
	logic [CB:0]   stack_mem [STACK_DEPTH];
	logic [CB-1:0] nat_mem   [QUEUE_DEPTH];
	logic [CB-1:0] intl_mem  [QUEUE_DEPTH];

	// control state
	logic [LB-1:0]   limit_q;
	logic [SP_W-1:0] sp_q,        sp_d;
	logic [QA_W-1:0] nat_head_q,  nat_head_d;
	logic [QA_W-1:0] intl_head_q, intl_head_d;
	logic [QC_W-1:0] nat_cnt_q,   nat_cnt_d;
	logic [QC_W-1:0] intl_cnt_q,  intl_cnt_d;
	logic            out_valid_q;

	// captured item and registered memory reads
	sttcq_pkg::op_t  op_q;
	logic [CB-1:0]   code_q;
	logic            cls_q;
	logic            sel_q;
	logic [CB:0]     stack_rd_q;
	logic [CB-1:0]   nat_rd_q;
	logic [CB-1:0]   intl_rd_q;

	// result register
	sttcq_pkg::status_t status_q, status_d;
	logic [CB-1:0]      code_res_q, code_res_d;
	logic               cls_res_q,  cls_res_d;
	logic [CNT_W-1:0]   count_q;

	logic            stack_we, nat_we, intl_we;
	logic [SP_W-1:0] sp_dec;
	logic [SA_W-1:0] top_idx;
	logic            reg_ok;
	logic            top_cls;
	logic [QC_W:0]   nat_sum, intl_sum;
	logic [QA_W-1:0] nat_tail, intl_tail;

	assign sp_dec  = sp_q - 1'b1;
	assign top_idx = sp_dec[SA_W-1:0];
	assign top_cls = stack_rd_q[CB];
	// limit above the depth saturates at the depth
	assign reg_ok  = (CMP_W'(sp_q) < CMP_W'(limit_q)) && (CMP_W'(sp_q) < DEPTH_CMP);

	// tail = (head + count) mod depth; the sum stays below twice the depth
	assign nat_sum   = (QC_W + 1)'(nat_head_q) + (QC_W + 1)'(nat_cnt_q);
	assign intl_sum  = (QC_W + 1)'(intl_head_q) + (QC_W + 1)'(intl_cnt_q);
	assign nat_tail  = (nat_sum >= Q_WRAP) ? QA_W'(nat_sum - Q_WRAP) : QA_W'(nat_sum);
	assign intl_tail = (intl_sum >= Q_WRAP) ? QA_W'(intl_sum - Q_WRAP) : QA_W'(intl_sum);

	always_comb begin
		sp_d        = sp_q;
		nat_head_d  = nat_head_q;
		intl_head_d = intl_head_q;
		nat_cnt_d   = nat_cnt_q;
		intl_cnt_d  = intl_cnt_q;
		status_d    = sttcq_pkg::ST_DONE;
		code_res_d  = '0;
		cls_res_d   = 1'b0;
		stack_we    = 1'b0;
		nat_we      = 1'b0;
		intl_we     = 1'b0;
		case (op_q)
			sttcq_pkg::OP_REGISTER: begin
				if (reg_ok) begin
					stack_we   = 1'b1;
					sp_d       = sp_q + 1'b1;
					code_res_d = code_q;
					cls_res_d  = cls_q;
				end else begin
					status_d = sttcq_pkg::ST_STACK_FULL;
				end
			end
			sttcq_pkg::OP_DISTRIBUTE: begin
				if (sp_q == '0) begin
					status_d = sttcq_pkg::ST_STACK_EMPTY;
				end else if (top_cls ? (intl_cnt_q == Q_FULL) : (nat_cnt_q == Q_FULL)) begin
					status_d = sttcq_pkg::ST_QUEUE_FULL;
				end else begin
					if (top_cls) begin
						intl_we    = 1'b1;
						intl_cnt_d = intl_cnt_q + 1'b1;
					end else begin
						nat_we    = 1'b1;
						nat_cnt_d = nat_cnt_q + 1'b1;
					end
					sp_d       = sp_dec;
					code_res_d = stack_rd_q[CB-1:0];
					cls_res_d  = top_cls;
				end
			end
			sttcq_pkg::OP_SEND: begin
				if (sel_q ? (intl_cnt_q == '0) : (nat_cnt_q == '0)) begin
					status_d = sttcq_pkg::ST_QUEUE_EMPTY;
				end else if (sel_q) begin
					code_res_d  = intl_rd_q;
					cls_res_d   = 1'b1;
					intl_cnt_d  = intl_cnt_q - 1'b1;
					intl_head_d = (intl_head_q == Q_LAST) ? '0 : intl_head_q + 1'b1;
				end else begin
					code_res_d = nat_rd_q;
					nat_cnt_d  = nat_cnt_q - 1'b1;
					nat_head_d = (nat_head_q == Q_LAST) ? '0 : nat_head_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= sttcq_pkg::LIMIT_RESET;
			sp_q        <= '0;
			nat_head_q  <= '0;
			intl_head_q <= '0;
			nat_cnt_q   <= '0;
			intl_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.commit) begin
				sp_q        <= sp_d;
				nat_head_q  <= nat_head_d;
				intl_head_q <= intl_head_d;
				nat_cnt_q   <= nat_cnt_d;
				intl_cnt_q  <= intl_cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and memories
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= sttcq_pkg::op_t'(operation);
			code_q     <= item_code;
			cls_q      <= item_international;
			sel_q      <= queue_select;
			stack_rd_q <= stack_mem[top_idx];
			nat_rd_q   <= nat_mem[nat_head_q];
			intl_rd_q  <= intl_mem[intl_head_q];
		end
		if (cmd.commit) begin
			status_q   <= status_d;
			code_res_q <= code_res_d;
			cls_res_q  <= cls_res_d;
			count_q    <= CNT_W'(sp_d);
			if (stack_we) stack_mem[sp_q[SA_W-1:0]] <= {cls_q, code_q};
			if (nat_we)   nat_mem[nat_tail]         <= stack_rd_q[CB-1:0];
			if (intl_we)  intl_mem[intl_tail]       <= stack_rd_q[CB-1:0];
		end
	end

	assign stat.out_free     = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign out_code          = code_res_q;
	assign out_international = cls_res_q;
	assign stack_count       = count_q;

endmodule

### src/stack_to_two_class_queues.sv
// Top level: LIFO stack of tagged items feeding one FIFO queue per class.
//
// Channels: req (sink) carries operation, item_code, item_international and
// queue_select; rsp (source) returns status, out_code, out_international and
// stack_count. Both transfer on valid && ready. cfg_we/cfg_wdata write the
// stack limit; write only while no operation is in flight.
// Each operation returns exactly one result. A transferred request is captured
// with a registered read of the stack and queue memories (S_IDLE); the update
// and the result register load follow in S_EXEC once the result register is
// free. A new request is taken only after that update has been committed.
// While the result register is stalled by the receiver a new request is still
// taken; its update then waits until the held result transfers, and req.ready
// stays low meanwhile.
// Reset: stack and both queues empty, limit 8, no result pending. Memory
// contents are not cleared; only data from occupied slots is ever used.
module stack_to_two_class_queues #(
	parameter int STACK_DEPTH = sttcq_pkg::STACK_DEPTH_DEF,
	parameter int QUEUE_DEPTH = sttcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sttcq_req_if.sink                         req,
	sttcq_rsp_if.source                       rsp,
	input  logic                              cfg_we,
	input  logic [sttcq_pkg::LIMIT_BITS-1:0]  cfg_wdata
);

	sttcq_pkg::ctrl_cmd_t  cmd;
	sttcq_pkg::dp_status_t stat;

	sttcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sttcq_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.operation          (req.operation),
		.item_code          (req.item_code),
		.item_international (req.item_international),
		.queue_select       (req.queue_select),
		.cmd                (cmd),
		.stat               (stat),
		.out_valid          (rsp.valid),
		.out_ready          (rsp.ready),
		.status             (rsp.status),
		.out_code           (rsp.out_code),
		.out_international  (rsp.out_international),
		.stack_count        (rsp.stack_count)
	);

`ifndef SYNTHESIS
	// one operation at a time: no new transfer right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous operation in flight");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.commit)
		else $error("capture and commit in the same cycle");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != sttcq_pkg::ST_DONE))
			|-> (rsp.out_code == '0) && !rsp.out_international)
		else $error("refused operation reports an item");
`endif

endmodule
